// ===== sv/bptc_pkg.sv =====
// Shared types, constants and the control program of the pressure compensation unit.
package bptc_pkg;

  localparam int unsigned NumCoef = 6;
  localparam int unsigned CoefW   = 16;
  localparam int unsigned RawW    = 24;
  localparam int unsigned ResW    = 32;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned PcW     = 6;
  localparam int unsigned AccW    = 64;
  localparam int unsigned MulW    = 33;
  localparam int unsigned ShW     = 5;

  // Widths of the stored intermediate values, sized to their ranges.
  localparam int unsigned DtW    = 26;
  localparam int unsigned DtempW = 20;
  localparam int unsigned TempW  = 24;
  localparam int unsigned T2W    = 20;
  localparam int unsigned SqW    = 40;
  localparam int unsigned WideW  = 48;

  // Temperature thresholds in 0.01 degree C.
  localparam int TempRef = 2000;
  localparam int TempLow = -1500;

  // Fixed shift amounts of the compensation formulas.
  localparam int unsigned ShC5      = 8;
  localparam int unsigned ShC2      = 16;
  localparam int unsigned ShC1      = 15;
  localparam int unsigned ShDtemp   = 23;
  localparam int unsigned ShOffLin  = 7;
  localparam int unsigned ShSensLin = 8;
  localparam int unsigned ShT2      = 31;
  localparam int unsigned ShPress1  = 21;
  localparam int unsigned ShPress2  = 15;
  localparam int unsigned ShSplit   = 16;

  localparam logic signed [AccW-1:0] PresMax = {{(AccW-ResW+1){1'b0}}, {(ResW-1){1'b1}}};
  localparam logic signed [AccW-1:0] PresMin = {{(AccW-ResW+1){1'b1}}, {(ResW-1){1'b0}}};

  typedef enum logic [CfgIdxW-1:0] {
    REG_C1 = 3'd0,
    REG_C2 = 3'd1,
    REG_C3 = 3'd2,
    REG_C4 = 3'd3,
    REG_C5 = 3'd4,
    REG_C6 = 3'd5
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ALU_NOP,
    ALU_LOAD,
    ALU_ADD,
    ALU_SUB
  } alu_op_e;

  typedef enum logic [3:0] {
    SRC_ACC,
    SRC_PROD,
    SRC_D2,
    SRC_C1,
    SRC_C2,
    SRC_C5,
    SRC_K2000,
    SRC_K1500,
    SRC_TEMP,
    SRC_OFF,
    SRC_SENS,
    SRC_T2,
    SRC_SQ,
    SRC_OFF2,
    SRC_SENS2
  } src_e;

  typedef enum logic [3:0] {
    DST_NONE,
    DST_DT,
    DST_DTEMP,
    DST_TEMP,
    DST_OFF,
    DST_SENS,
    DST_T2,
    DST_SQ,
    DST_OFF2,
    DST_SENS2
  } dst_e;

  typedef enum logic [3:0] {
    MOP_DT,
    MOP_C6,
    MOP_C4,
    MOP_C3,
    MOP_DTEMP,
    MOP_SQ,
    MOP_D1,
    MOP_SENS_LO,
    MOP_SENS_HI
  } mop_e;

  typedef enum logic [1:0] {
    JMP_NONE,
    JMP_TEMP_GE_REF,
    JMP_TEMP_GE_LOW
  } jmp_e;

  typedef struct packed {
    alu_op_e        op;
    src_e           src;
    logic           sh_left;
    logic [ShW-1:0] sh_amt;
    dst_e           dst;
    logic           mul_en;
    mop_e           ma;
    mop_e           mb;
    jmp_e           jmp;
    logic [PcW-1:0] target;
    logic           fin;
  } uword_t;

  localparam logic [PcW-1:0] StepApply = PcW'(25);
  localparam logic [PcW-1:0] StepPress = PcW'(31);
  localparam logic [PcW-1:0] StepFin   = PcW'(37);

  function automatic uword_t alu_w(alu_op_e op, src_e src, logic sh_left, int unsigned sh,
                                   dst_e dst);
    uword_t w;
    w.op      = op;
    w.src     = src;
    w.sh_left = sh_left;
    w.sh_amt  = ShW'(sh);
    w.dst     = dst;
    w.mul_en  = 1'b0;
    w.ma      = MOP_DT;
    w.mb      = MOP_DT;
    w.jmp     = JMP_NONE;
    w.target  = '0;
    w.fin     = 1'b0;
    return w;
  endfunction

  function automatic uword_t mul_w(uword_t w_in, mop_e ma, mop_e mb);
    uword_t w;
    w        = w_in;
    w.mul_en = 1'b1;
    w.ma     = ma;
    w.mb     = mb;
    return w;
  endfunction

  function automatic uword_t jmp_w(uword_t w_in, jmp_e cond, logic [PcW-1:0] target);
    uword_t w;
    w        = w_in;
    w.jmp    = cond;
    w.target = target;
    return w;
  endfunction

  function automatic uword_t nop_w();
    return alu_w(ALU_NOP, SRC_ACC, 1'b0, 0, DST_NONE);
  endfunction

  // The control program. Products are registered, so a product issued in one step
  // is read in the next step or later.
  function automatic uword_t ucode_rom(logic [PcW-1:0] pc);
    uword_t w;
    unique case (pc)
      // dT = D2 - C5 * 256
      PcW'(0):  w = alu_w(ALU_LOAD, SRC_D2, 1'b0, 0, DST_NONE);
      PcW'(1):  w = alu_w(ALU_SUB, SRC_C5, 1'b1, ShC5, DST_DT);
      PcW'(2):  w = mul_w(nop_w(), MOP_DT, MOP_C6);
      // First-order temperature, offset and sensitivity.
      PcW'(3):  w = mul_w(alu_w(ALU_LOAD, SRC_PROD, 1'b0, ShDtemp, DST_DTEMP), MOP_C4, MOP_DT);
      PcW'(4):  w = alu_w(ALU_ADD, SRC_K2000, 1'b0, 0, DST_TEMP);
      PcW'(5):  w = mul_w(alu_w(ALU_LOAD, SRC_PROD, 1'b0, ShOffLin, DST_NONE), MOP_C3, MOP_DT);
      PcW'(6):  w = alu_w(ALU_ADD, SRC_C2, 1'b1, ShC2, DST_OFF);
      PcW'(7):  w = mul_w(alu_w(ALU_LOAD, SRC_PROD, 1'b0, ShSensLin, DST_NONE), MOP_DT, MOP_DT);
      PcW'(8):  w = jmp_w(alu_w(ALU_ADD, SRC_C1, 1'b1, ShC1, DST_SENS), JMP_TEMP_GE_REF,
                          StepPress);
      // Cold correction: T2, and five times dTemp squared in two shares.
      PcW'(9):  w = mul_w(alu_w(ALU_LOAD, SRC_PROD, 1'b0, ShT2, DST_T2), MOP_DTEMP, MOP_DTEMP);
      PcW'(10): w = alu_w(ALU_LOAD, SRC_PROD, 1'b1, 2, DST_NONE);
      PcW'(11): w = alu_w(ALU_ADD, SRC_PROD, 1'b0, 0, DST_SQ);
      PcW'(12): w = alu_w(ALU_LOAD, SRC_SQ, 1'b0, 1, DST_OFF2);
      PcW'(13): w = jmp_w(alu_w(ALU_LOAD, SRC_SQ, 1'b0, 2, DST_SENS2), JMP_TEMP_GE_LOW,
                          StepApply);
      // Very cold correction: seven and eleven halves of (TEMP + 1500) squared.
      PcW'(14): w = alu_w(ALU_LOAD, SRC_TEMP, 1'b0, 0, DST_NONE);
      PcW'(15): w = alu_w(ALU_ADD, SRC_K1500, 1'b0, 0, DST_SQ);
      PcW'(16): w = mul_w(nop_w(), MOP_SQ, MOP_SQ);
      PcW'(17): w = alu_w(ALU_LOAD, SRC_OFF2, 1'b0, 0, DST_NONE);
      PcW'(18): w = alu_w(ALU_ADD, SRC_PROD, 1'b1, 3, DST_NONE);
      PcW'(19): w = alu_w(ALU_SUB, SRC_PROD, 1'b0, 0, DST_OFF2);
      PcW'(20): w = alu_w(ALU_LOAD, SRC_PROD, 1'b1, 3, DST_NONE);
      PcW'(21): w = alu_w(ALU_ADD, SRC_PROD, 1'b1, 1, DST_NONE);
      PcW'(22): w = alu_w(ALU_ADD, SRC_PROD, 1'b0, 0, DST_SQ);
      PcW'(23): w = alu_w(ALU_LOAD, SRC_SENS2, 1'b0, 0, DST_NONE);
      PcW'(24): w = alu_w(ALU_ADD, SRC_SQ, 1'b0, 1, DST_SENS2);
      // Apply the corrections.
      PcW'(25): w = alu_w(ALU_LOAD, SRC_TEMP, 1'b0, 0, DST_NONE);
      PcW'(26): w = alu_w(ALU_SUB, SRC_T2, 1'b0, 0, DST_TEMP);
      PcW'(27): w = alu_w(ALU_LOAD, SRC_OFF, 1'b0, 0, DST_NONE);
      PcW'(28): w = alu_w(ALU_SUB, SRC_OFF2, 1'b0, 0, DST_OFF);
      PcW'(29): w = alu_w(ALU_LOAD, SRC_SENS, 1'b0, 0, DST_NONE);
      PcW'(30): w = alu_w(ALU_SUB, SRC_SENS2, 1'b0, 0, DST_SENS);
      // Pressure: D1 * SENS in two partial products, then the two shifts. The low
      // product is taken into the accumulator while the high one is being formed.
      PcW'(31): w = mul_w(nop_w(), MOP_D1, MOP_SENS_LO);
      PcW'(32): w = mul_w(alu_w(ALU_LOAD, SRC_PROD, 1'b0, 0, DST_NONE), MOP_D1, MOP_SENS_HI);
      PcW'(33): w = alu_w(ALU_ADD, SRC_PROD, 1'b1, ShSplit, DST_NONE);
      PcW'(34): w = alu_w(ALU_LOAD, SRC_ACC, 1'b0, ShPress1, DST_NONE);
      PcW'(35): w = alu_w(ALU_SUB, SRC_OFF, 1'b0, 0, DST_NONE);
      PcW'(36): w = alu_w(ALU_LOAD, SRC_ACC, 1'b0, ShPress2, DST_NONE);
      default: begin
        w     = nop_w();
        w.fin = 1'b1;
      end
    endcase
    return w;
  endfunction

endpackage

// ===== sv/baro_pressure_temp_compensation_unit.sv =====
// Top level of the barometric pressure and temperature compensation unit.
//
// The unit takes one request of raw pressure (D1) and raw temperature (D2) and
// returns one result of compensated pressure and temperature in 0.01 units, using
// the six calibration words C1..C6 written through the configuration port while
// the unit is idle. The math is the standard second-order compensation with a
// further term below -15.00 C; pressure saturates to signed 32 bits. A request
// with zero raw pressure returns the last computed results with the held flag set.
// The work runs on one shared 33 x 33 bit multiplier and one 64-bit accumulator,
// steered by a 38-step control program, and the multiplier and accumulator are
// what set the pace. At or above 20.00 C the program skips both corrections;
// between -15.00 C and 20.00 C it skips only the very cold one; below -15.00 C
// it runs every step; a held request runs only the final step. The next request
// is taken in the cycle after the result is loaded into the output register. A
// result waits in that register without blocking the next request, but the last
// step holds until the register is free.
module baro_pressure_temp_compensation_unit (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [bptc_pkg::CfgIdxW-1:0]         cfg_idx_i,
  input  logic [bptc_pkg::CoefW-1:0]           cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [bptc_pkg::RawW-1:0]            raw_pressure_i,
  input  logic [bptc_pkg::RawW-1:0]            raw_temperature_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [bptc_pkg::ResW-1:0]     pressure_o,
  output logic signed [bptc_pkg::ResW-1:0]     temperature_o,
  output logic                                 held_o
);
  import bptc_pkg::*;

  // Calibration words.
  logic [CoefW-1:0] coef_q [NumCoef];

  // Sequencer control.
  logic           busy_q;
  logic [PcW-1:0] pc_q, pc_d;
  logic           item_held_q;
  uword_t         uw;

  // Captured request.
  logic [RawW-1:0] d1_q, d2_q;

  // Datapath registers.
  logic signed [AccW-1:0]   acc_q, acc_d;
  logic signed [AccW-1:0]   prod_q;
  logic signed [DtW-1:0]    dt_q;
  logic signed [DtempW-1:0] dtemp_q;
  logic signed [TempW-1:0]  temp_q;
  logic signed [T2W-1:0]    t2_q;
  logic signed [SqW-1:0]    sq_q;
  logic signed [WideW-1:0]  off_q, sens_q, off2_q, sens2_q;

  // Result side.
  logic                   out_valid_q;
  logic signed [ResW-1:0] out_p_q, out_t_q;
  logic                   out_held_q;
  logic signed [ResW-1:0] held_p_q, held_t_q;

  logic signed [AccW-1:0]   opnd, opnd_sh;
  logic signed [MulW-1:0]   ma_v, mb_v;
  logic signed [2*MulW-1:0] prod_full;
  logic                     jmp_take;
  logic                     out_free;
  logic                     fin_fire;
  logic                     in_fire;
  logic signed [ResW-1:0]   sat_p;

  assign uw         = ucode_rom(pc_q);
  assign in_ready_o = !busy_q;
  assign in_fire    = in_valid_i && !busy_q;
  assign out_free   = !out_valid_q || out_ready_i;
  assign fin_fire   = busy_q && uw.fin && out_free;

  // Configuration writes; indexes beyond the last word are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumCoef; i++) begin
        coef_q[i] <= '0;
      end
    end else if (cfg_we_i && (cfg_idx_i < CfgIdxW'(NumCoef))) begin
      coef_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  // Accumulator operand: select, then shift left or arithmetic right.
  always_comb begin
    unique case (uw.src)
      SRC_ACC:   opnd = acc_q;
      SRC_PROD:  opnd = prod_q;
      SRC_D2:    opnd = AccW'(d2_q);
      SRC_C1:    opnd = AccW'(coef_q[REG_C1]);
      SRC_C2:    opnd = AccW'(coef_q[REG_C2]);
      SRC_C5:    opnd = AccW'(coef_q[REG_C5]);
      SRC_K2000: opnd = AccW'(TempRef);
      SRC_K1500: opnd = AccW'(-TempLow);
      SRC_TEMP:  opnd = AccW'(temp_q);
      SRC_OFF:   opnd = AccW'(off_q);
      SRC_SENS:  opnd = AccW'(sens_q);
      SRC_T2:    opnd = AccW'(t2_q);
      SRC_SQ:    opnd = AccW'(sq_q);
      SRC_OFF2:  opnd = AccW'(off2_q);
      SRC_SENS2: opnd = AccW'(sens2_q);
      default:   opnd = '0;
    endcase
    opnd_sh = uw.sh_left ? (opnd <<< uw.sh_amt) : (opnd >>> uw.sh_amt);
  end

  always_comb begin
    unique case (uw.op)
      ALU_NOP:  acc_d = acc_q;
      ALU_LOAD: acc_d = opnd_sh;
      ALU_ADD:  acc_d = acc_q + opnd_sh;
      ALU_SUB:  acc_d = acc_q - opnd_sh;
      default:  acc_d = acc_q;
    endcase
  end

  // Multiplier operands. SENS is split into a low unsigned 16-bit part and a signed upper part.
  always_comb begin
    unique case (uw.ma)
      MOP_DT:      ma_v = MulW'(dt_q);
      MOP_C6:      ma_v = MulW'(coef_q[REG_C6]);
      MOP_C4:      ma_v = MulW'(coef_q[REG_C4]);
      MOP_C3:      ma_v = MulW'(coef_q[REG_C3]);
      MOP_DTEMP:   ma_v = MulW'(dtemp_q);
      MOP_SQ:      ma_v = MulW'(sq_q);
      MOP_D1:      ma_v = MulW'(d1_q);
      MOP_SENS_LO: ma_v = MulW'(sens_q[ShSplit-1:0]);
      MOP_SENS_HI: ma_v = MulW'(sens_q >>> ShSplit);
      default:     ma_v = '0;
    endcase
    unique case (uw.mb)
      MOP_DT:      mb_v = MulW'(dt_q);
      MOP_C6:      mb_v = MulW'(coef_q[REG_C6]);
      MOP_C4:      mb_v = MulW'(coef_q[REG_C4]);
      MOP_C3:      mb_v = MulW'(coef_q[REG_C3]);
      MOP_DTEMP:   mb_v = MulW'(dtemp_q);
      MOP_SQ:      mb_v = MulW'(sq_q);
      MOP_D1:      mb_v = MulW'(d1_q);
      MOP_SENS_LO: mb_v = MulW'(sens_q[ShSplit-1:0]);
      MOP_SENS_HI: mb_v = MulW'(sens_q >>> ShSplit);
      default:     mb_v = '0;
    endcase
  end

  assign prod_full = ma_v * mb_v;

  // Branches test the first-order temperature against the two thresholds.
  always_comb begin
    unique case (uw.jmp)
      JMP_NONE:        jmp_take = 1'b0;
      JMP_TEMP_GE_REF: jmp_take = (temp_q >= TempRef);
      JMP_TEMP_GE_LOW: jmp_take = (temp_q >= TempLow);
      default:         jmp_take = 1'b0;
    endcase
  end

  always_comb begin
    if (jmp_take) begin
      pc_d = uw.target;
    end else begin
      pc_d = pc_q + PcW'(1);
    end
  end

  // Saturate the final accumulator to the signed 32-bit range.
  always_comb begin
    if (acc_q > PresMax) begin
      sat_p = PresMax[ResW-1:0];
    end else if (acc_q < PresMin) begin
      sat_p = PresMin[ResW-1:0];
    end else begin
      sat_p = acc_q[ResW-1:0];
    end
  end

  // Sequencer. A held request goes straight to the final step.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      pc_q        <= '0;
      item_held_q <= 1'b0;
    end else if (in_fire) begin
      busy_q      <= 1'b1;
      item_held_q <= (raw_pressure_i == '0);
      pc_q        <= (raw_pressure_i == '0) ? StepFin : '0;
    end else if (fin_fire) begin
      busy_q <= 1'b0;
    end else if (busy_q && !uw.fin) begin
      pc_q <= pc_d;
    end
  end

  // Request capture and datapath; payload only, no reset needed.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      d1_q <= raw_pressure_i;
      d2_q <= raw_temperature_i;
    end
    if (busy_q) begin
      acc_q <= acc_d;
      if (uw.mul_en) begin
        prod_q <= prod_full[AccW-1:0];
      end
      unique case (uw.dst)
        DST_NONE:  ;
        DST_DT:    dt_q    <= acc_d[DtW-1:0];
        DST_DTEMP: dtemp_q <= acc_d[DtempW-1:0];
        DST_TEMP:  temp_q  <= acc_d[TempW-1:0];
        DST_OFF:   off_q   <= acc_d[WideW-1:0];
        DST_SENS:  sens_q  <= acc_d[WideW-1:0];
        DST_T2:    t2_q    <= acc_d[T2W-1:0];
        DST_SQ:    sq_q    <= acc_d[SqW-1:0];
        DST_OFF2:  off2_q  <= acc_d[WideW-1:0];
        DST_SENS2: sens2_q <= acc_d[WideW-1:0];
        default:   ;
      endcase
    end
  end

  // Held results are the state that a zero-pressure request returns.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_p_q <= '0;
      held_t_q <= '0;
    end else if (fin_fire && !item_held_q) begin
      held_p_q <= sat_p;
      held_t_q <= ResW'(temp_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fin_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin_fire) begin
      out_held_q <= item_held_q;
      if (item_held_q) begin
        out_p_q <= held_p_q;
        out_t_q <= held_t_q;
      end else begin
        out_p_q <= sat_p;
        out_t_q <= ResW'(temp_q);
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign pressure_o    = out_p_q;
  assign temperature_o = out_t_q;
  assign held_o        = out_held_q;

  // A zero-pressure request skips the program and ends in the final step.
  a_held_skips: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && (raw_pressure_i == '0) |=> (pc_q == StepFin) && item_held_q)
    else $error("held request did not go to the final step");

  // A measured request starts the program at its first step.
  a_start_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && (raw_pressure_i != '0) |=> (pc_q == '0) && !item_held_q)
    else $error("measured request did not start at step zero");

  // The presented result always matches the held state.
  a_out_matches_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_p_q == held_p_q) && (out_t_q == held_t_q))
    else $error("presented result differs from held state");

  // The step counter never runs past the final step.
  a_pc_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (pc_q <= StepFin))
    else $error("step counter ran past the program");

endmodule
